// File: rtl/rabs_pkg.sv
// ----------------------------------------------------------------------------
// rabs_pkg
// Shared types and constants for the running-average background subtractor.
// ----------------------------------------------------------------------------
package rabs_pkg;

	localparam int MAX_PIXELS  = 131072;
	localparam int POS_W       = $clog2(MAX_PIXELS);
	localparam int PIX_W       = 8;
	localparam int ALPHA_W     = 16;
	localparam int THRESH_W    = 8;
	localparam int WEIGHT_W    = 17;
	localparam int FRAMES_W    = 16;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int CFG_IDX_W   = 1;

	localparam logic [WEIGHT_W-1:0] Q16_ONE      = WEIGHT_W'(65536);
	localparam logic [FRAMES_W-1:0] FRAMES_MAX   = {FRAMES_W{1'b1}};
	localparam logic [ALPHA_W-1:0]  ALPHA_RESET  = ALPHA_W'(655);
	localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(25);

	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 1'b1;

	typedef enum logic {
		CMD_PIXEL = 1'b0,
		CMD_RESET = 1'b1
	} cmd_t;

	typedef struct packed {
		cmd_t             kind;
		logic [PIX_W-1:0] pixel;
		logic             last;
	} item_t;

	typedef struct packed {
		logic [ALPHA_W-1:0]  alpha;
		logic [THRESH_W-1:0] thresh;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_WRITE,
		ST_W_MUL,
		ST_W_CHK,
		ST_W_DIV
	} back_state_t;

endpackage

// File: rtl/rabs_ram.sv
// ----------------------------------------------------------------------------
// rabs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rabs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/rabs_div.sv
// ----------------------------------------------------------------------------
// rabs_div
// Restoring divider, one quotient bit per cycle: 1.0 (Q16) / divisor.
// ----------------------------------------------------------------------------
module rabs_div import rabs_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [WEIGHT_W-1:0] divisor,
	output logic                busy,
	output logic [WEIGHT_W-1:0] quotient
);

	localparam int CNT_W = $clog2(WEIGHT_W + 1);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [WEIGHT_W-1:0] rem_q;
	logic [WEIGHT_W-1:0] quo_q;
	logic [WEIGHT_W-1:0] den_q;
	logic [WEIGHT_W:0]   rem_sh;
	logic [WEIGHT_W:0]   rem_sub;
	logic                ge;

	// quo_q shifts the dividend out at the top while quotient bits enter at the bottom
	assign rem_sh  = {rem_q, quo_q[WEIGHT_W-1]};
	assign ge      = rem_sh >= {1'b0, den_q};
	assign rem_sub = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(WEIGHT_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= Q16_ONE;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub[WEIGHT_W-1:0] : rem_sh[WEIGHT_W-1:0];
			quo_q <= {quo_q[WEIGHT_W-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

// File: rtl/rabs_front.sv
// ----------------------------------------------------------------------------
// rabs_front
// Input side: accepts items, tags them as pixel or model reset, and holds
// them in a short queue until the back end takes them.
// ----------------------------------------------------------------------------
module rabs_front import rabs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic             cmd,
	input  logic [PIX_W-1:0] pixel,
	input  logic             last_in_frame,
	output logic             q_valid,
	output item_t            q_item,
	input  logic             q_pop
);

	item_t             slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;
	item_t             in_item;

	assign full    = count_q == QCNT_W'(QUEUE_DEPTH);
	assign q_valid = count_q != '0;
	assign do_push = push && !full;
	assign do_pop  = q_pop && q_valid;

	always_comb begin
		in_item.kind  = cmd_t'(cmd);
		in_item.pixel = pixel;
		// frame end means nothing on a reset command
		in_item.last  = last_in_frame && (cmd_t'(cmd) == CMD_PIXEL);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!do_push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= in_item;
		end
	end

	assign q_item = slot_q[rd_ptr_q];

endmodule

// File: rtl/rabs_back.sv
// ----------------------------------------------------------------------------
// rabs_back
// Execution side: read-modify-write of the background store, foreground
// decision, result register, and the per-frame weight update.
// ----------------------------------------------------------------------------
module rabs_back import rabs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  item_t            q_item,
	output logic             q_pop,
	input  cfg_t             cfg,
	output logic             empty,
	input  logic             pop,
	output logic             foreground,
	output logic [PIX_W-1:0] model_value,
	output logic             frame_end
);

	localparam int MIX_W  = WEIGHT_W + PIX_W + 1;
	localparam int PROD_W = WEIGHT_W + ALPHA_W;
	localparam logic [MIX_W-1:0] ROUND_HALF = MIX_W'(32768);

	back_state_t         state_q, state_d;
	logic [POS_W-1:0]    pos_q;
	logic [FRAMES_W-1:0] frames_q;
	logic [FRAMES_W-1:0] frames_next;
	logic [WEIGHT_W-1:0] weight_q;
	logic [WEIGHT_W-1:0] count_q;
	logic                early_q;
	logic [PIX_W-1:0]    pix_s1;
	logic                last_s1;
	logic [PIX_W-1:0]    upd_s2;

	logic                out_valid_q;
	logic                out_fg_q;
	logic [PIX_W-1:0]    out_model_q;
	logic                out_end_q;
	logic                out_free;

	logic                ram_re, ram_we, out_load, div_start;
	logic [PIX_W-1:0]    ram_rdata;
	logic [PIX_W-1:0]    old_val;
	logic [MIX_W-1:0]    mix;
	logic [PIX_W-1:0]    blend;
	logic [PIX_W-1:0]    diff;
	logic [PROD_W-1:0]   prod;
	logic                div_busy;
	logic [WEIGHT_W-1:0] div_quo;

	rabs_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_PIXELS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (pos_q),
		.wdata (upd_s2),
		.re    (ram_re),
		.raddr (pos_q),
		.rdata (ram_rdata)
	);

	rabs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  (count_q),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	assign out_free = !out_valid_q || pop;

	// full weight ignores the stored value, which may never have been written
	assign old_val = weight_q[WEIGHT_W-1] ? '0 : ram_rdata;
	assign mix = MIX_W'(weight_q) * MIX_W'(pix_s1)
		+ MIX_W'(Q16_ONE - weight_q) * MIX_W'(old_val) + ROUND_HALF;
	assign blend = (mix[MIX_W-1:16] > (MIX_W-16)'(255)) ? {PIX_W{1'b1}} : mix[16 +: PIX_W];

	assign diff        = (pix_s1 > upd_s2) ? pix_s1 - upd_s2 : upd_s2 - pix_s1;
	assign frames_next = (frames_q == FRAMES_MAX) ? frames_q : frames_q + 1'b1;
	assign prod        = PROD_W'(count_q) * PROD_W'(cfg.alpha);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid && q_item.kind == CMD_PIXEL) begin
					state_d = ST_READ;
				end
			end
			ST_READ:  state_d = ST_WRITE;
			ST_WRITE: begin
				if (out_free) begin
					state_d = last_s1 ? ST_W_MUL : ST_IDLE;
				end
			end
			ST_W_MUL: state_d = ST_W_CHK;
			ST_W_CHK: state_d = early_q ? ST_W_DIV : ST_IDLE;
			ST_W_DIV: begin
				if (!div_busy) begin
					state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		q_pop     = 1'b0;
		ram_re    = 1'b0;
		ram_we    = 1'b0;
		out_load  = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				q_pop  = q_valid;
				ram_re = q_valid && q_item.kind == CMD_PIXEL;
			end
			ST_WRITE: begin
				ram_we   = out_free;
				out_load = out_free;
			end
			ST_W_CHK: div_start = early_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			frames_q    <= '0;
			weight_q    <= Q16_ONE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (q_pop && q_item.kind == CMD_RESET) begin
				pos_q    <= '0;
				frames_q <= '0;
				weight_q <= Q16_ONE;
			end
			if (out_load) begin
				if (last_s1) begin
					pos_q    <= '0;
					frames_q <= frames_next;
				end else begin
					pos_q <= (pos_q == POS_W'(MAX_PIXELS - 1)) ? '0 : pos_q + 1'b1;
				end
			end
			if (state_q == ST_W_CHK && !early_q) begin
				weight_q <= WEIGHT_W'(cfg.alpha);
			end
			if (state_q == ST_W_DIV && !div_busy) begin
				weight_q <= div_quo;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ram_re) begin
			pix_s1  <= q_item.pixel;
			last_s1 <= q_item.last;
		end
		if (state_q == ST_READ) begin
			upd_s2 <= blend;
		end
		if (out_load) begin
			out_fg_q    <= diff > cfg.thresh;
			out_model_q <= upd_s2;
			out_end_q   <= last_s1;
			count_q     <= WEIGHT_W'(frames_next) + 1'b1;
		end
		if (state_q == ST_W_MUL) begin
			early_q <= prod < PROD_W'(Q16_ONE);
		end
	end

	assign empty       = !out_valid_q;
	assign foreground  = out_fg_q;
	assign model_value = out_model_q;
	assign frame_end   = out_end_q;

endmodule

// File: rtl/running_average_background_subtract_core.sv
// ----------------------------------------------------------------------------
// running_average_background_subtract_core
// Per-pixel running-average background model with foreground detection.
// ----------------------------------------------------------------------------
// Usage:
//  Input queue port: push/full with cmd, pixel and last_in_frame. A pixel
//  item (cmd low) yields one result; a reset command (cmd high) restarts the
//  frame count and raster position and yields none.
//  Result queue port: empty/pop with foreground, model_value and frame_end.
//  Config port: cfg_valid/cfg_ready (always ready), cfg_index 0 = alpha_q16,
//  1 = diff_threshold. A new alpha is picked up at the next frame end.
//  Timing: a pixel passes through read, blend and write-back on the single
//  background RAM; its result is registered at write-back, which waits while
//  an earlier result is unread. The last pixel of a frame adds the weight
//  check (multiply, compare), plus the divider while the 1/(n+1) weight
//  applies. A reset command is taken from the queue while the back end idles.
//  A two-deep input queue keeps taking items while a result waits; if pop
//  stays low the back end holds the next result at write-back and the input
//  side fills, raising full.
//  After arst_n: empty high, full low, weight at full, config at defaults.
// ----------------------------------------------------------------------------
module running_average_background_subtract_core import rabs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic                 cmd,
	input  logic [PIX_W-1:0]     pixel,
	input  logic                 last_in_frame,
	output logic                 empty,
	input  logic                 pop,
	output logic                 foreground,
	output logic [PIX_W-1:0]     model_value,
	output logic                 frame_end,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ALPHA_W-1:0]   cfg_data
);

	cfg_t  cfg_q;
	logic  q_valid;
	logic  q_pop;
	item_t q_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alpha  <= ALPHA_RESET;
			cfg_q.thresh <= THRESH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ALPHA:  cfg_q.alpha  <= cfg_data;
				CFG_THRESH: cfg_q.thresh <= cfg_data[THRESH_W-1:0];
				default: ;
			endcase
		end
	end

	rabs_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.cmd           (cmd),
		.pixel         (pixel),
		.last_in_frame (last_in_frame),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop)
	);

	rabs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop),
		.cfg         (cfg_q),
		.empty       (empty),
		.pop         (pop),
		.foreground  (foreground),
		.model_value (model_value),
		.frame_end   (frame_end)
	);

endmodule

// File: rtl/rabs_checker.sv
// ----------------------------------------------------------------------------
// rabs_checker
// Port-level checks on the background subtractor, bound to the top level.
// ----------------------------------------------------------------------------
module rabs_checker import rabs_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             push,
	input logic             full,
	input logic             empty,
	input logic             pop,
	input logic             foreground,
	input logic [PIX_W-1:0] model_value,
	input logic             frame_end
);

	// a waiting result holds until taken
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(model_value)
			&& $stable(foreground) && $stable(frame_end)))
		else $error("result changed or vanished while stalled");

	// leaving reset: result queue empty, input queue not full
	a_reset_state: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> (empty && !full))
		else $error("queues not clear after reset");

	// the input queue only fills on a push
	a_full_needs_push: assert property (@(posedge clk) disable iff (!arst_n)
		(!full && !push) |=> !full)
		else $error("full rose without a push");

endmodule

bind running_average_background_subtract_core rabs_checker u_rabs_checker (.*);
